/* rtl/hsv_to_rgb_converter_macros.svh */
// Assertion macros shared by the HSV to RGB converter RTL.
// Depends on nothing; files that check their logic include it.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HSVRGB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication that lands a fixed number of cycles later.
`define HSVRGB_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

/* rtl/hsvrgb_pkg.sv */
// Package for the HSV to RGB converter: field widths, fixed-point constants
// and the hue sector type. No dependencies.
package hsvrgb_pkg;

  localparam int HUE_W    = 17;
  localparam int SAT_W    = 9;
  localparam int CH_W     = 8;
  localparam int IDX_W    = 4;   // raw sector count before the 360 degree wrap, 0..8
  localparam int FRAC_W   = 14;
  localparam int PROD_W   = 23;  // frac * saturation
  localparam int K_W      = 22;  // channel weight, at most one sector times 1.0

  localparam int SECTOR_COUNTS = 15360;           // 60 degrees, 8 fraction bits
  localparam int K_FULL        = SECTOR_COUNTS * 256;
  localparam int MAX_IDX       = 8;               // 17-bit hue stays below 9 sectors
  localparam int LATENCY       = 7;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW,
    SEC_YELLOW_GREEN,
    SEC_GREEN_CYAN,
    SEC_CYAN_BLUE,
    SEC_BLUE_MAGENTA,
    SEC_MAGENTA_RED
  } sector_e;

endpackage

/* rtl/hsvrgb_scale.sv */
// Two-stage channel scaler: brightness times weight, then *255 / (15 * 2^26)
// done as *17 >> 26, clamped to a byte. Uses hsvrgb_pkg.
module hsvrgb_scale (
  input  logic                          clk_i,
  input  logic [hsvrgb_pkg::SAT_W-1:0]  val_i,
  input  logic [hsvrgb_pkg::K_W-1:0]    k_i,
  output logic [hsvrgb_pkg::CH_W-1:0]   chan_o
);

  localparam int MUL_W = hsvrgb_pkg::SAT_W + hsvrgb_pkg::K_W;
  localparam int X17_W = MUL_W + 5;
  localparam int SHIFT = 26;

  logic [MUL_W-1:0]            prod_d, prod_q;
  logic [X17_W-1:0]            x17;
  logic [X17_W-SHIFT-1:0]      raw;
  logic [hsvrgb_pkg::CH_W-1:0] chan_d, chan_q;

  assign prod_d = MUL_W'(val_i) * MUL_W'(k_i);

  // 255/(15*2^26) == 17/2^26 exactly, so the floor matches the exact divide
  assign x17    = {5'b0, prod_q}
                + {1'b0, prod_q, 4'b0};
  assign raw    = x17[X17_W-1:SHIFT];
  assign chan_d = (|raw[X17_W-SHIFT-1:hsvrgb_pkg::CH_W]) ? '1 : raw[hsvrgb_pkg::CH_W-1:0];

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    chan_q <= chan_d;
  end

  assign chan_o = chan_q;

endmodule

/* rtl/hsv_to_rgb_converter.sv */
// HSV to RGB converter, top level: seven-stage pipeline, one pixel per clock.
// Uses hsvrgb_pkg, hsvrgb_scale and hsv_to_rgb_converter_macros.svh.
//
// Usage:
//   An item is taken at a rising edge with start_i high and busy_o low.
//   busy_o is always low: the pipeline takes a new pixel every cycle.
//   hue_i is degrees with 8 fraction bits (wraps at 360), saturation_i and
//   brightness_i are Q1.8 with 256 meaning 1.0.
//   After acceptance valid_o is high for one cycle with
//   red_o, green_o and blue_o; items leave in order, one per cycle at most.
//   Latency is set by the stage chain: sector search, fraction, weight
//   products, weight subtract, brightness multiply, scale and clamp, and the
//   output register.
//   The receiver cannot stall, and none is needed: nothing here waits.
//   Reset (rst_ni low, asynchronous) drops every item in flight; the data
//   path registers are not reset.
`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [hsvrgb_pkg::HUE_W-1:0]  hue_i,
  input  logic [hsvrgb_pkg::SAT_W-1:0]  saturation_i,
  input  logic [hsvrgb_pkg::SAT_W-1:0]  brightness_i,
  output logic                          valid_o,
  output logic [hsvrgb_pkg::CH_W-1:0]   red_o,
  output logic [hsvrgb_pkg::CH_W-1:0]   green_o,
  output logic [hsvrgb_pkg::CH_W-1:0]   blue_o
);

  localparam int SAT_W  = hsvrgb_pkg::SAT_W;
  localparam int HUE_W  = hsvrgb_pkg::HUE_W;
  localparam int IDX_W  = hsvrgb_pkg::IDX_W;
  localparam int FRAC_W = hsvrgb_pkg::FRAC_W;
  localparam int PROD_W = hsvrgb_pkg::PROD_W;
  localparam int K_W    = hsvrgb_pkg::K_W;
  localparam int CH_W   = hsvrgb_pkg::CH_W;
  localparam int LAT    = hsvrgb_pkg::LATENCY;

  logic [LAT-1:0] vld_d, vld_q;

  // stage 1: raw sector index
  logic [IDX_W-1:0] idx_d, idx_q;
  logic [HUE_W-1:0] hue_q;
  logic [SAT_W-1:0] sat1_q, val1_q;

  // stage 2: fraction and wrapped sector
  logic [FRAC_W-1:0]     frac_d, frac_q;
  hsvrgb_pkg::sector_e   sec_d, sec2_q, sec3_q, sec4_q, sec5_q, sec6_q;
  logic [SAT_W-1:0]      sat2_q, val2_q;

  // stage 3: weight products
  logic [PROD_W-1:0] pq_d, pq_q, pt_d, pt_q;
  logic [SAT_W-1:0]  kp_d, kp_q, val3_q;

  // stage 4: channel weights
  logic [K_W-1:0]    kq_d, kq_q, kt_d, kt_q, kpw_d, kpw_q;
  logic [SAT_W-1:0]  val4_q;

  logic [CH_W-1:0] cv, cp, cq, ct;
  logic [CH_W-1:0] red_d, green_d, blue_d, red_q, green_q, blue_q;

  assign busy_o = 1'b0;
  assign vld_d  = {vld_q[LAT-2:0], start_i};

  always_comb begin
    idx_d = '0;
    for (int k = 1; k <= hsvrgb_pkg::MAX_IDX; k++) begin
      if (hue_i >= HUE_W'(k * hsvrgb_pkg::SECTOR_COUNTS)) begin
        idx_d = IDX_W'(k);
      end
    end
  end

  assign frac_d = FRAC_W'(hue_q - HUE_W'(idx_q * HUE_W'(hsvrgb_pkg::SECTOR_COUNTS)));
  assign sec_d  = (idx_q >= IDX_W'(6)) ? hsvrgb_pkg::sector_e'(3'(idx_q - IDX_W'(6)))
                                       : hsvrgb_pkg::sector_e'(idx_q[2:0]);

  assign pq_d = PROD_W'(frac_q) * PROD_W'(sat2_q);
  assign pt_d = PROD_W'(FRAC_W'(hsvrgb_pkg::SECTOR_COUNTS) - frac_q) * PROD_W'(sat2_q);
  assign kp_d = (sat2_q >= SAT_W'(256)) ? '0 : SAT_W'(256) - sat2_q;

  // a weight at or below zero gives a black channel
  assign kq_d  = (pq_q >= PROD_W'(hsvrgb_pkg::K_FULL)) ? '0
               : K_W'(PROD_W'(hsvrgb_pkg::K_FULL) - pq_q);
  assign kt_d  = (pt_q >= PROD_W'(hsvrgb_pkg::K_FULL)) ? '0
               : K_W'(PROD_W'(hsvrgb_pkg::K_FULL) - pt_q);
  assign kpw_d = K_W'(kp_q * hsvrgb_pkg::SECTOR_COUNTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    hue_q   <= hue_i;
    sat1_q  <= saturation_i;
    val1_q  <= brightness_i;
    frac_q  <= frac_d;
    sec2_q  <= sec_d;
    sat2_q  <= sat1_q;
    val2_q  <= val1_q;
    pq_q    <= pq_d;
    pt_q    <= pt_d;
    kp_q    <= kp_d;
    sec3_q  <= sec2_q;
    val3_q  <= val2_q;
    kq_q    <= kq_d;
    kt_q    <= kt_d;
    kpw_q   <= kpw_d;
    sec4_q  <= sec3_q;
    val4_q  <= val3_q;
    sec5_q  <= sec4_q;
    sec6_q  <= sec5_q;
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  hsvrgb_scale u_scale_v (.clk_i, .val_i(val4_q), .k_i(K_W'(hsvrgb_pkg::K_FULL)), .chan_o(cv));
  hsvrgb_scale u_scale_p (.clk_i, .val_i(val4_q), .k_i(kpw_q), .chan_o(cp));
  hsvrgb_scale u_scale_q (.clk_i, .val_i(val4_q), .k_i(kq_q),  .chan_o(cq));
  hsvrgb_scale u_scale_t (.clk_i, .val_i(val4_q), .k_i(kt_q),  .chan_o(ct));

  always_comb begin
    case (sec6_q)
      hsvrgb_pkg::SEC_RED_YELLOW:   begin red_d = cv; green_d = ct; blue_d = cp; end
      hsvrgb_pkg::SEC_YELLOW_GREEN: begin red_d = cq; green_d = cv; blue_d = cp; end
      hsvrgb_pkg::SEC_GREEN_CYAN:   begin red_d = cp; green_d = cv; blue_d = ct; end
      hsvrgb_pkg::SEC_CYAN_BLUE:    begin red_d = cp; green_d = cq; blue_d = cv; end
      hsvrgb_pkg::SEC_BLUE_MAGENTA: begin red_d = ct; green_d = cp; blue_d = cv; end
      default:                      begin red_d = cv; green_d = cp; blue_d = cq; end
    endcase
  end

  assign valid_o = vld_q[LAT-1];
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  `HSVRGB_ASSERT_DLY(a_latency, start_i, 7, valid_o, "accepted item did not come out on time")
  `HSVRGB_ASSERT_IMP(a_idx_range, vld_q[0], idx_q <= IDX_W'(hsvrgb_pkg::MAX_IDX), "sector index out of range")
  `HSVRGB_ASSERT_IMP(a_frac_range, vld_q[1], frac_q < FRAC_W'(hsvrgb_pkg::SECTOR_COUNTS), "fraction not below one sector")
  `HSVRGB_ASSERT_IMP(a_sec_range, vld_q[1], sec2_q <= hsvrgb_pkg::SEC_MAGENTA_RED, "wrapped sector above five")
  `HSVRGB_ASSERT_DLY(a_black, start_i && brightness_i == '0, 7, red_o == '0 && green_o == '0 && blue_o == '0, "zero brightness gave a lit pixel")

endmodule

/* verif/tb_hsv_to_rgb_converter.sv */
// Self-checking testbench for hsv_to_rgb_converter: directed pixel table, then random pixels
// under three sender gap profiles, checked against table colors or an in-bench predictor.
// Depends on hsvrgb_pkg and the hsv_to_rgb_converter RTL.
module tb_hsv_to_rgb_converter;

  localparam int HUE_W          = hsvrgb_pkg::HUE_W;
  localparam int SAT_W          = hsvrgb_pkg::SAT_W;
  localparam int CH_W           = hsvrgb_pkg::CH_W;
  localparam int SECTOR_COUNTS  = hsvrgb_pkg::SECTOR_COUNTS;
  localparam int K_FULL         = hsvrgb_pkg::K_FULL;
  localparam int MAX_IDX        = hsvrgb_pkg::MAX_IDX;
  localparam int LATENCY        = hsvrgb_pkg::LATENCY;

  localparam int CLK_PERIOD     = 20;
  localparam int FULL_TURN      = 6 * SECTOR_COUNTS;
  localparam int CH_MAX         = 255;
  localparam int RAND_PER_PHASE = 630;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int MAX_REPORTS    = 150;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [SAT_W-1:0] val;
  } hsv_pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_pixel_t;

  // typed = 1: the color is read straight off the row, otherwise predicted
  typedef struct packed {
    hsv_pixel_t pix;
    bit         typed;
    rgb_pixel_t rgb;
  } color_row_t;

  localparam int NUM_ROWS = 23;
  localparam color_row_t COLOR_ROWS [NUM_ROWS] = '{
    '{'{17'd0,      9'd0,   9'd0  }, 1'b1, '{8'd0,   8'd0,   8'd0  }},
    '{'{17'd0,      9'd256, 9'd0  }, 1'b1, '{8'd0,   8'd0,   8'd0  }},
    '{'{17'd0,      9'd0,   9'd256}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{'{17'd0,      9'd0,   9'd511}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{'{17'd0,      9'd0,   9'd128}, 1'b1, '{8'd127, 8'd127, 8'd127}},
    '{'{17'd0,      9'd256, 9'd256}, 1'b1, '{8'd255, 8'd0,   8'd0  }},
    '{'{17'd15360,  9'd256, 9'd256}, 1'b1, '{8'd255, 8'd255, 8'd0  }},
    '{'{17'd30720,  9'd256, 9'd256}, 1'b1, '{8'd0,   8'd255, 8'd0  }},
    '{'{17'd46080,  9'd256, 9'd256}, 1'b1, '{8'd0,   8'd255, 8'd255}},
    '{'{17'd61440,  9'd256, 9'd256}, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{'{17'd76800,  9'd256, 9'd256}, 1'b1, '{8'd255, 8'd0,   8'd255}},
    '{'{17'd92160,  9'd256, 9'd256}, 1'b1, '{8'd255, 8'd0,   8'd0  }},
    '{'{17'd107520, 9'd256, 9'd256}, 1'b1, '{8'd255, 8'd255, 8'd0  }},
    '{'{17'd0,      9'd511, 9'd256}, 1'b1, '{8'd255, 8'd0,   8'd0  }},
    '{'{17'd92159,  9'd256, 9'd256}, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{'{17'd131071, 9'd256, 9'd256}, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{'{17'd7680,   9'd511, 9'd256}, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{'{17'd7680,   9'd128, 9'd256}, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{'{17'd38400,  9'd200, 9'd511}, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{'{17'd15359,  9'd256, 9'd256}, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{'{17'd65536,  9'd255, 9'd255}, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{'{17'd131071, 9'd511, 9'd511}, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{'{17'd46081,  9'd1,   9'd1  }, 1'b0, '{8'd0,   8'd0,   8'd0  }}
  };

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             start_i      = 1'b0;
  logic [HUE_W-1:0] hue_i        = '0;
  logic [SAT_W-1:0] saturation_i = '0;
  logic [SAT_W-1:0] brightness_i = '0;
  logic             busy_o;
  logic             valid_o;
  logic [CH_W-1:0]  red_o;
  logic [CH_W-1:0]  green_o;
  logic [CH_W-1:0]  blue_o;

  rgb_pixel_t  rgb_due_q [$];
  int unsigned err_count  = 0;
  int unsigned report_cnt = 0;
  int unsigned gap_pct    = 0;

  hsv_to_rgb_converter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .hue_i       (hue_i),
    .saturation_i(saturation_i),
    .brightness_i(brightness_i),
    .valid_o     (valid_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // brightness * weight * 255 / (256 * full weight), truncated, then clamped
  function automatic logic [CH_W-1:0] scale_term(longint v, longint k);
    longint lvl;
    if (k <= 0 || v <= 0) begin
      return '0;
    end
    lvl = (v * k * CH_MAX) / (longint'(256) * K_FULL);
    if (lvl > CH_MAX) begin
      lvl = CH_MAX;
    end
    return lvl[CH_W-1:0];
  endfunction

  function automatic rgb_pixel_t rgb_of_hsv(hsv_pixel_t pix);
    longint              wrapped, frac, s, v;
    hsvrgb_pkg::sector_e sec;
    logic [CH_W-1:0]     cv, cp, cq, ct;
    rgb_pixel_t          rgb;
    wrapped = longint'(pix.hue) % FULL_TURN;
    sec     = hsvrgb_pkg::sector_e'(wrapped / SECTOR_COUNTS);
    frac    = wrapped % SECTOR_COUNTS;
    s       = longint'(pix.sat);
    v       = longint'(pix.val);
    cv = scale_term(v, K_FULL);
    cp = scale_term(v, K_FULL - SECTOR_COUNTS * s);
    cq = scale_term(v, K_FULL - frac * s);
    ct = scale_term(v, K_FULL - (SECTOR_COUNTS - frac) * s);
    case (sec)
      hsvrgb_pkg::SEC_RED_YELLOW:   rgb = '{cv, ct, cp};
      hsvrgb_pkg::SEC_YELLOW_GREEN: rgb = '{cq, cv, cp};
      hsvrgb_pkg::SEC_GREEN_CYAN:   rgb = '{cp, cv, ct};
      hsvrgb_pkg::SEC_CYAN_BLUE:    rgb = '{cp, cq, cv};
      hsvrgb_pkg::SEC_BLUE_MAGENTA: rgb = '{ct, cp, cv};
      default:                      rgb = '{cv, cp, cq};
    endcase
    return rgb;
  endfunction

  // mostly in-range pixels, plus sector edges, corner levels and raw wide fields
  function automatic hsv_pixel_t rand_pixel();
    hsv_pixel_t  pix;
    int unsigned k;
    pix.hue = HUE_W'($urandom_range(FULL_TURN - 1));
    pix.sat = SAT_W'($urandom_range(256));
    pix.val = SAT_W'($urandom_range(256));
    case ($urandom_range(9))
      6: pix = hsv_pixel_t'($urandom);
      7: begin
        k = $urandom_range(MAX_IDX) * SECTOR_COUNTS + $urandom_range(2);
        pix.hue = HUE_W'((k == 0) ? 0 : k - 1);
      end
      8: begin
        pix.sat = $urandom_range(1) ? SAT_W'(256) : SAT_W'($urandom_range(1) ? 511 : 0);
        pix.val = $urandom_range(1) ? SAT_W'(256) : SAT_W'($urandom_range(1) ? 511 : 255);
      end
      9: pix.hue = HUE_W'($urandom);
      default: ;
    endcase
    return pix;
  endfunction

  // gaps hit at random per cycle, junk on the fields while start is low
  task automatic drive_pixel(hsv_pixel_t pix, rgb_pixel_t rgb);
    while ($urandom_range(99) < gap_pct) begin
      start_i      <= 1'b0;
      hue_i        <= HUE_W'($urandom);
      saturation_i <= SAT_W'($urandom);
      brightness_i <= SAT_W'($urandom);
      @(posedge clk_i);
    end
    start_i      <= 1'b1;
    hue_i        <= pix.hue;
    saturation_i <= pix.sat;
    brightness_i <= pix.val;
    do begin
      @(posedge clk_i);
    end while (busy_o);
    rgb_due_q.push_back(rgb);
  endtask

  always @(posedge clk_i) begin : color_check
    rgb_pixel_t want;
    if (rst_ni && valid_o) begin
      if (rgb_due_q.size() == 0) begin
        err_count++;
        if (report_cnt < MAX_REPORTS) begin
          report_cnt++;
          $display("%0t: unexpected item rgb=%0d,%0d,%0d", $time, red_o, green_o, blue_o);
        end
      end else begin
        want = rgb_due_q.pop_front();
        if (red_o !== want.red) begin
          err_count++;
          if (report_cnt < MAX_REPORTS) begin
            report_cnt++;
            $display("%0t: red expected %0d actual %0d", $time, want.red, red_o);
          end
        end
        if (green_o !== want.green) begin
          err_count++;
          if (report_cnt < MAX_REPORTS) begin
            report_cnt++;
            $display("%0t: green expected %0d actual %0d", $time, want.green, green_o);
          end
        end
        if (blue_o !== want.blue) begin
          err_count++;
          if (report_cnt < MAX_REPORTS) begin
            report_cnt++;
            $display("%0t: blue expected %0d actual %0d", $time, want.blue, blue_o);
          end
        end
      end
    end
  end

  initial begin : stimulus
    hsv_pixel_t  pix;
    int unsigned drain;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct = 30;
    foreach (COLOR_ROWS[i]) begin
      drive_pixel(COLOR_ROWS[i].pix,
                  COLOR_ROWS[i].typed ? COLOR_ROWS[i].rgb : rgb_of_hsv(COLOR_ROWS[i].pix));
    end

    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 30 : (ph == 1) ? 53 : 0;
      repeat (RAND_PER_PHASE) begin
        pix = rand_pixel();
        drive_pixel(pix, rgb_of_hsv(pix));
      end
    end
    start_i <= 1'b0;

    drain = 0;
    while (rgb_due_q.size() != 0 && drain < 20 * LATENCY) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (LATENCY + 3) @(posedge clk_i);
    if (rgb_due_q.size() != 0) begin
      err_count += rgb_due_q.size();
      $display("%0t: %0d items never came out", $time, rgb_due_q.size());
    end

    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("%0t: run timed out", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/hsvrgb_pkg.sv
rtl/hsvrgb_scale.sv
rtl/hsv_to_rgb_converter.sv
verif/tb_hsv_to_rgb_converter.sv
